// File: hdl/pph_pkg.sv
// ----------------------------------------------------------------------------
// pph_pkg
// Shared widths, codes and types of the perturbed-probe hash table.
// ----------------------------------------------------------------------------
package pph_pkg;

	localparam int HASH_W   = 32;
	localparam int KEY_W    = 64;
	localparam int SLOT_W   = 10;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;
	localparam int SHIFT_W  = 4;
	localparam int EFF_W    = 5;

	localparam int PERTURB_SHR = 5;
	localparam int MIN_SHIFT   = 3;

	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ENTER  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MARK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MARKED    = 3'd4;

	// outcome of one probe plus the next point of the probe walk
	typedef struct packed {
		logic              empty;
		logic              hit;
		logic [HASH_W-1:0] next_j;
		logic [HASH_W-1:0] next_perturb;
	} pph_step_t;

endpackage

// File: hdl/pph_in_if.sv
// ----------------------------------------------------------------------------
// pph_in_if
// Request channel: operation, hash, key and mark write fields.
// ----------------------------------------------------------------------------
interface pph_in_if
	import pph_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [HASH_W-1:0]   key_hash;
	logic [KEY_W-1:0]    key_value;
	logic [SLOT_W-1:0]   target_slot;
	logic                defined_value;

	modport source (
		output valid, mode, key_hash, key_value, target_slot, defined_value,
		input  ready
	);
	modport sink (
		input  valid, mode, key_hash, key_value, target_slot, defined_value,
		output ready
	);
endinterface

// File: hdl/pph_out_if.sv
// ----------------------------------------------------------------------------
// pph_out_if
// Response channel: status, slot and defined mark of the slot.
// ----------------------------------------------------------------------------
interface pph_out_if
	import pph_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic                entry_defined;

	modport source (
		output valid, status, slot_index, entry_defined,
		input  ready
	);
	modport sink (
		input  valid, status, slot_index, entry_defined,
		output ready
	);
endinterface

// File: hdl/pph_cfg_if.sv
// ----------------------------------------------------------------------------
// pph_cfg_if
// Configuration write channel carrying the table size register.
// ----------------------------------------------------------------------------
interface pph_cfg_if
	import pph_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [SHIFT_W-1:0] data;

	modport source (
		output valid, data,
		input  ready
	);
	modport sink (
		input  valid, data,
		output ready
	);
endinterface

// File: hdl/pph_slot_mem.sv
// ----------------------------------------------------------------------------
// pph_slot_mem
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pph_slot_mem #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 98
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);
	logic [DATA_W-1:0] mem [(1 << ADDR_W)];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// File: hdl/pph_probe_step.sv
// ----------------------------------------------------------------------------
// pph_probe_step
// Probe unit: checks one slot word and steps the perturbed probe walk.
// ----------------------------------------------------------------------------
module pph_probe_step
	import pph_pkg::*;
#(
	parameter int KEY_BITS = 64
) (
	input  logic [HASH_W-1:0]         cur_j,
	input  logic [HASH_W-1:0]         cur_perturb,
	input  logic [2+HASH_W+KEY_BITS-1:0] slot_word,
	input  logic [HASH_W-1:0]         key_hash,
	input  logic [KEY_BITS-1:0]       key_value,
	output pph_step_t                 step
);
	localparam int WORD_W = 2 + HASH_W + KEY_BITS;

	logic                slot_used;
	logic                slot_def;
	logic [HASH_W-1:0]   slot_hash;
	logic [KEY_BITS-1:0] slot_key;

	assign slot_used = slot_word[WORD_W-1];
	assign slot_def  = slot_word[WORD_W-2];
	assign slot_hash = slot_word[KEY_BITS +: HASH_W];
	assign slot_key  = slot_word[KEY_BITS-1:0];

	always_comb begin
		step.empty        = !slot_used;
		step.hit          = slot_used && slot_def && (slot_hash == key_hash)
			&& (slot_key == key_value);
		// j = 5*j + perturb + 1, wrapping at 32 bits
		step.next_j       = (cur_j << 2) + cur_j + cur_perturb + HASH_W'(1);
		step.next_perturb = cur_perturb >> PERTURB_SHR;
	end
endmodule

// File: hdl/perturbed_probe_hash_table_top.sv
// ----------------------------------------------------------------------------
// perturbed_probe_hash_table_top
// Open-addressing hash table with perturbed probing. The table size register
// (log2 of slots, clamped to 3..MAX_SHIFT) is written through cfg. After
// reset the block first sweeps the slot store clear and takes no request
// until that is done. A lookup or enter reads one slot per probe, since the
// store has a single read port and each probe is one read; its result then
// passes S_DONE into the output register. A mark write reads and rewrites the
// target slot in S_MARK, and a reserved mode goes straight to S_DONE. The next
// request is taken once the result is in the output register, even while that
// result still waits to be taken.
// ----------------------------------------------------------------------------
module perturbed_probe_hash_table_top
	import pph_pkg::*;
#(
	parameter int MAX_SHIFT = 10,
	parameter int KEY_BITS  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	pph_cfg_if.sink    cfg,
	pph_in_if.sink     req,
	pph_out_if.source  rsp
);
	localparam int IDX_W  = MAX_SHIFT;
	localparam int CNT_W  = MAX_SHIFT + 1;
	localparam int LIM_W  = MAX_SHIFT + 2;
	localparam int WORD_W = 2 + HASH_W + KEY_BITS;
	localparam int WIDE_W = IDX_W + SLOT_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE,
		S_MARK,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [SHIFT_W-1:0]   shift_q;
	logic [IDX_W-1:0]     clr_q;
	logic [CNT_W-1:0]     count_q;
	logic [MODE_W-1:0]    mode_q;
	logic [HASH_W-1:0]    hash_q;
	logic [KEY_BITS-1:0]  key_q;
	logic                 def_in_q;
	logic [HASH_W-1:0]    j_q;
	logic [HASH_W-1:0]    pert_q;
	logic [IDX_W-1:0]     slot_q;
	logic [LIM_W-1:0]     n_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic [SLOT_W-1:0]    res_slot_q;
	logic                 res_def_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic                 out_def_q;

	logic [EFF_W-1:0]     eff;
	logic [IDX_W-1:0]     mask;
	logic [LIM_W-1:0]     limit;
	logic [CNT_W-1:0]     thresh;
	logic                 table_full;
	logic                 last_probe;
	logic [WIDE_W-1:0]    tgt_wide;
	logic [IDX_W-1:0]     tgt_slot;
	logic [WIDE_W-1:0]    slot_wide;
	logic [SLOT_W-1:0]    slot_out;

	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic [WORD_W-1:0]    rd_word;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [WORD_W-1:0]    wr_data;
	pph_step_t            step;

	// clamp of the size register and the values that follow from it
	always_comb begin
		if (shift_q < SHIFT_W'(MIN_SHIFT)) begin
			eff = EFF_W'(MIN_SHIFT);
		end else if ({1'b0, shift_q} > EFF_W'(MAX_SHIFT)) begin
			eff = EFF_W'(MAX_SHIFT);
		end else begin
			eff = {1'b0, shift_q};
		end
		for (int i = 0; i < IDX_W; i++) begin
			mask[i] = (EFF_W'(i) < eff);
		end
		limit  = (LIM_W'(1) << eff) + LIM_W'(8);
		thresh = CNT_W'((LIM_W'(3) << eff) >> 2);
	end

	assign table_full = (count_q >= thresh);
	assign last_probe = ((n_q + LIM_W'(1)) == limit);
	assign tgt_wide   = WIDE_W'(req.target_slot);
	assign tgt_slot   = tgt_wide[IDX_W-1:0] & mask;
	assign slot_wide  = WIDE_W'(slot_q);
	assign slot_out   = slot_wide[SLOT_W-1:0];

	pph_probe_step #(
		.KEY_BITS (KEY_BITS)
	) u_step (
		.cur_j       (j_q),
		.cur_perturb (pert_q),
		.slot_word   (rd_word),
		.key_hash    (hash_q),
		.key_value   (key_q),
		.step        (step)
	);

	pph_slot_mem #(
		.ADDR_W (IDX_W),
		.DATA_W (WORD_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	// store read and write control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = step.next_j[IDX_W-1:0] & mask;
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = {1'b1, 1'b0, hash_q, key_q};
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_IDLE: begin
				rd_en = req.valid;
				if (req.mode == MODE_MARK) begin
					rd_addr = tgt_slot;
				end else begin
					rd_addr = req.key_hash[IDX_W-1:0] & mask;
				end
			end
			S_PROBE: begin
				rd_en = !step.empty && !step.hit && !last_probe;
				// claim of the first unused slot
				wr_en = step.empty && (mode_q == MODE_ENTER) && !table_full;
			end
			S_MARK: begin
				wr_en   = rd_word[WORD_W-1];
				wr_data = {1'b1, def_in_q, rd_word[WORD_W-3:0]};
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			shift_q     <= SHIFT_W'(MIN_SHIFT);
			clr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				shift_q <= cfg.data;
			end
			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						mode_q   <= req.mode;
						hash_q   <= req.key_hash;
						key_q    <= req.key_value[KEY_BITS-1:0];
						def_in_q <= req.defined_value;
						j_q      <= req.key_hash;
						pert_q   <= req.key_hash;
						slot_q   <= rd_addr;
						n_q      <= '0;
						if (req.mode == MODE_LOOKUP || req.mode == MODE_ENTER) begin
							state_q <= S_PROBE;
						end else if (req.mode == MODE_MARK) begin
							state_q <= S_MARK;
						end else begin
							res_status_q <= ST_NOT_FOUND;
							res_slot_q   <= '0;
							res_def_q    <= 1'b0;
							state_q      <= S_DONE;
						end
					end
				end
				S_PROBE: begin
					if (step.empty) begin
						res_slot_q <= slot_out;
						res_def_q  <= 1'b0;
						if (mode_q == MODE_LOOKUP) begin
							res_status_q <= ST_NOT_FOUND;
						end else if (table_full) begin
							res_status_q <= ST_FULL;
						end else begin
							res_status_q <= ST_INSERTED;
							count_q      <= count_q + CNT_W'(1);
						end
						state_q <= S_DONE;
					end else if (step.hit) begin
						res_status_q <= ST_FOUND;
						res_slot_q   <= slot_out;
						res_def_q    <= 1'b1;
						state_q      <= S_DONE;
					end else if (last_probe) begin
						// walk covered every slot without an unused one
						res_status_q <= (mode_q == MODE_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
						res_slot_q   <= '0;
						res_def_q    <= 1'b0;
						state_q      <= S_DONE;
					end else begin
						j_q    <= step.next_j;
						pert_q <= step.next_perturb;
						slot_q <= rd_addr;
						n_q    <= n_q + LIM_W'(1);
					end
				end
				S_MARK: begin
					res_status_q <= ST_MARKED;
					res_slot_q   <= slot_out;
					res_def_q    <= rd_word[WORD_W-1] & def_in_q;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						out_def_q    <= res_def_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cfg.ready         = 1'b1;
	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.slot_index    = out_slot_q;
	assign rsp.entry_defined = out_def_q;
endmodule

// File: hdl/pph_checker.sv
// ----------------------------------------------------------------------------
// pph_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module pph_checker
	import pph_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [SLOT_W-1:0]   rsp_slot_index,
	input logic                rsp_entry_defined
);
	// a waiting result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_slot_index) && $stable(rsp_entry_defined))
		else $error("result beat changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= ST_MARKED)
		else $error("undefined status code");

	// a match needs the defined mark
	a_found_def: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FOUND |-> rsp_entry_defined)
		else $error("found entry without defined mark");

	a_miss_def: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_INSERTED || rsp_status == ST_NOT_FOUND
			|| rsp_status == ST_FULL) |-> !rsp_entry_defined)
		else $error("defined mark set on a miss or a new entry");
endmodule

bind perturbed_probe_hash_table_top pph_checker u_pph_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_slot_index    (rsp.slot_index),
	.rsp_entry_defined (rsp.entry_defined)
);
